FILE: design/ihq_pkg.sv
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and constants for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

	localparam int CAPACITY_DEF      = 256;
	localparam int ID_SPACE_DEF      = 256;
	localparam int PRIORITY_BITS_DEF = 32;

	localparam logic [1:0] KIND_INSERT   = 2'd0;
	localparam logic [1:0] KIND_EXTRACT  = 2'd1;
	localparam logic [1:0] KIND_DECREASE = 2'd2;

	localparam logic [2:0] ERR_OK     = 3'd0;
	localparam logic [2:0] ERR_EMPTY  = 3'd1;
	localparam logic [2:0] ERR_FULL   = 3'd2;
	localparam logic [2:0] ERR_DUP    = 3'd3;
	localparam logic [2:0] ERR_BADDEC = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_DISP,
		S_UPST,
		S_UPCMP,
		S_UPWR,
		S_DKPOS,
		S_DKCMP,
		S_EXTOP,
		S_EXLAST,
		S_DNL,
		S_DNR,
		S_DNC,
		S_EXFIN,
		S_FIN
	} state_t;

endpackage

FILE: design/indexed_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap with position map and decrease-key.
// Insert sifts up, one compare per parent; decrease checks the map position
// and key, then sifts up; extract reads root and last entry, then sifts down;
// a flagged item ends early. One item at a time: busy is high from accept
// until the done strobe, and the next item can be taken in the done cycle.
// Reset clears presence bits, count and control; heap and map memories are
// not cleared. Results are strobed on done for one cycle; no stall.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_top #(
	parameter int CAPACITY      = ihq_pkg::CAPACITY_DEF,
	parameter int ID_SPACE      = ihq_pkg::ID_SPACE_DEF,
	parameter int PRIORITY_BITS = ihq_pkg::PRIORITY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [7:0]         id,
	input  logic signed [31:0] priority_req,
	output logic               done,
	output logic [7:0]         result_id,
	output logic [2:0]         error,
	output logic [8:0]         count
);

	localparam int SW  = $clog2(CAPACITY + 1);
	localparam int IW  = (ID_SPACE > 2) ? $clog2(ID_SPACE) : 1;
	localparam int PW  = PRIORITY_BITS;
	localparam int EW  = IW + PW;
	localparam int XW  = (IW > 8) ? IW : 8;
	localparam int CXW = (SW > 9) ? SW : 9;

	ihq_pkg::state_t state_q, state_d;

	logic [EW-1:0] hp [0:CAPACITY];
	logic [SW-1:0] pm [0:ID_SPACE-1];

	logic          h_re, h_we, p_re, p_we;
	logic [SW-1:0] h_ra, h_wa;
	logic [EW-1:0] h_wd;
	logic [IW-1:0] p_ra, p_wa;
	logic [SW-1:0] p_wd;
	logic [EW-1:0] hrd;
	logic [SW-1:0] prd;

	logic [ID_SPACE-1:0] present_q;
	logic [SW-1:0]       cnt_q, pos_q;
	logic [SW:0]         cid_q;
	logic [1:0]          kind_q;
	logic [7:0]          idr_q;
	logic [PW-1:0]       key_q;
	logic [IW-1:0]       res_q;
	logic [2:0]          err_q;
	logic                done_q;
	logic [EW-1:0]       left_q, last_q;

	logic [PW-1:0] key_in;
	logic [XW-1:0] id_ext, res_ext;
	logic [IW-1:0] idx;
	logic [CXW-1:0] cnt_ext;
	logic          mod_more, up_stop, up_more, bad_pos, has_r, dn_stop, dn_more, ex_more;
	logic [SW-1:0] pos_half;
	logic [SW:0]   nc;

	always_comb begin
		for (int b = 0; b < PW; b++) begin
			key_in[b] = priority_req[(b < 32) ? b : 31];
		end
	end

	assign id_ext   = XW'(idr_q);
	assign idx      = id_ext[IW-1:0];
	assign mod_more = 17'(idr_q) >= 17'(ID_SPACE);
	assign pos_half = pos_q >> 1;
	assign up_stop  = $signed(key_q) > $signed(hrd[PW-1:0]);
	assign up_more  = pos_half > SW'(1);
	assign bad_pos  = (prd == '0) || (prd > cnt_q);
	assign has_r    = cid_q < {1'b0, cnt_q};
	assign dn_stop  = $signed(last_q[PW-1:0]) <= $signed(left_q[PW-1:0]);
	assign nc       = {cid_q[SW-1:0], 1'b0};
	assign dn_more  = nc <= {1'b0, cnt_q};
	assign ex_more  = cnt_q >= SW'(3);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ihq_pkg::S_IDLE:   if (start) state_d = ihq_pkg::S_MOD;
			ihq_pkg::S_MOD:    if (!mod_more) state_d = ihq_pkg::S_DISP;
			ihq_pkg::S_DISP: begin
				case (kind_q)
					ihq_pkg::KIND_INSERT:
						state_d = (cnt_q >= SW'(CAPACITY) || present_q[idx]) ?
							ihq_pkg::S_FIN : ihq_pkg::S_UPST;
					ihq_pkg::KIND_EXTRACT:
						state_d = (cnt_q == '0) ? ihq_pkg::S_FIN : ihq_pkg::S_EXTOP;
					ihq_pkg::KIND_DECREASE:
						state_d = present_q[idx] ? ihq_pkg::S_DKPOS : ihq_pkg::S_FIN;
					default: state_d = ihq_pkg::S_FIN;
				endcase
			end
			ihq_pkg::S_UPST:   state_d = (pos_q > SW'(1)) ? ihq_pkg::S_UPCMP : ihq_pkg::S_UPWR;
			ihq_pkg::S_UPCMP:  if (up_stop || !up_more) state_d = ihq_pkg::S_UPWR;
			ihq_pkg::S_UPWR:   state_d = ihq_pkg::S_FIN;
			ihq_pkg::S_DKPOS:  state_d = bad_pos ? ihq_pkg::S_FIN : ihq_pkg::S_DKCMP;
			ihq_pkg::S_DKCMP:
				state_d = ($signed(key_q) >= $signed(hrd[PW-1:0])) ?
					ihq_pkg::S_FIN : ihq_pkg::S_UPST;
			ihq_pkg::S_EXTOP:  state_d = ihq_pkg::S_EXLAST;
			ihq_pkg::S_EXLAST: state_d = ex_more ? ihq_pkg::S_DNL : ihq_pkg::S_EXFIN;
			ihq_pkg::S_DNL:    state_d = has_r ? ihq_pkg::S_DNR : ihq_pkg::S_DNC;
			ihq_pkg::S_DNR:    state_d = ihq_pkg::S_DNC;
			ihq_pkg::S_DNC:
				state_d = (dn_stop || !dn_more) ? ihq_pkg::S_EXFIN : ihq_pkg::S_DNL;
			ihq_pkg::S_EXFIN:  state_d = ihq_pkg::S_FIN;
			ihq_pkg::S_FIN:    state_d = ihq_pkg::S_IDLE;
			default:           state_d = ihq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		h_re = 1'b0;
		h_ra = '0;
		h_we = 1'b0;
		h_wa = pos_q;
		h_wd = left_q;
		p_re = 1'b0;
		p_ra = idx;
		p_we = 1'b0;
		p_wa = left_q[EW-1:PW];
		p_wd = pos_q;
		case (state_q)
			ihq_pkg::S_DISP: begin
				h_re = (kind_q == ihq_pkg::KIND_EXTRACT);
				h_ra = SW'(1);
				p_re = (kind_q == ihq_pkg::KIND_DECREASE);
			end
			ihq_pkg::S_UPST: begin
				h_re = 1'b1;
				h_ra = pos_half;
			end
			ihq_pkg::S_UPCMP: begin
				if (!up_stop) begin
					h_we = 1'b1;
					h_wd = hrd;
					p_we = 1'b1;
					p_wa = hrd[EW-1:PW];
					h_re = up_more;
					h_ra = pos_half >> 1;
				end
			end
			ihq_pkg::S_UPWR: begin
				h_we = 1'b1;
				h_wd = {idx, key_q};
				p_we = 1'b1;
				p_wa = idx;
			end
			ihq_pkg::S_DKPOS: begin
				h_re = 1'b1;
				h_ra = prd;
			end
			ihq_pkg::S_EXTOP: begin
				h_re = 1'b1;
				h_ra = cnt_q;
			end
			ihq_pkg::S_EXLAST: begin
				h_re = 1'b1;
				h_ra = SW'(2);
			end
			ihq_pkg::S_DNL: begin
				h_re = has_r;
				h_ra = SW'(cid_q + 1'b1);
			end
			ihq_pkg::S_DNC: begin
				if (!dn_stop) begin
					h_we = 1'b1;
					p_we = 1'b1;
					h_re = dn_more;
					h_ra = nc[SW-1:0];
				end
			end
			ihq_pkg::S_EXFIN: begin
				h_we = (cnt_q != '0);
				h_wd = last_q;
				p_we = (cnt_q != '0);
				p_wa = last_q[EW-1:PW];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) hp[h_wa] <= h_wd;
		if (h_re) hrd <= hp[h_ra];
		if (p_we) pm[p_wa] <= p_wd;
		if (p_re) prd <= pm[p_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ihq_pkg::S_IDLE;
			present_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			err_q     <= ihq_pkg::ERR_OK;
			res_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ihq_pkg::S_FIN);
			case (state_q)
				ihq_pkg::S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						idr_q  <= id;
						key_q  <= key_in;
						err_q  <= ihq_pkg::ERR_OK;
						res_q  <= '0;
					end
				end
				ihq_pkg::S_MOD: if (mod_more) idr_q <= idr_q - 8'(ID_SPACE);
				ihq_pkg::S_DISP: begin
					case (kind_q)
						ihq_pkg::KIND_INSERT: begin
							if (cnt_q >= SW'(CAPACITY)) err_q <= ihq_pkg::ERR_FULL;
							else if (present_q[idx]) err_q <= ihq_pkg::ERR_DUP;
							else begin
								cnt_q          <= cnt_q + 1'b1;
								pos_q          <= cnt_q + 1'b1;
								present_q[idx] <= 1'b1;
							end
						end
						ihq_pkg::KIND_EXTRACT: if (cnt_q == '0) err_q <= ihq_pkg::ERR_EMPTY;
						ihq_pkg::KIND_DECREASE: if (!present_q[idx]) err_q <= ihq_pkg::ERR_BADDEC;
						default: ;
					endcase
				end
				ihq_pkg::S_UPCMP: if (!up_stop) pos_q <= pos_half;
				ihq_pkg::S_DKPOS: begin
					pos_q <= prd;
					if (bad_pos) err_q <= ihq_pkg::ERR_BADDEC;
				end
				ihq_pkg::S_DKCMP:
					if ($signed(key_q) >= $signed(hrd[PW-1:0])) err_q <= ihq_pkg::ERR_BADDEC;
				ihq_pkg::S_EXTOP: begin
					res_q                   <= hrd[EW-1:PW];
					present_q[hrd[EW-1:PW]] <= 1'b0;
				end
				ihq_pkg::S_EXLAST: begin
					last_q <= hrd;
					cnt_q  <= cnt_q - 1'b1;
					pos_q  <= SW'(1);
					cid_q  <= (SW + 1)'(2);
				end
				ihq_pkg::S_DNL: left_q <= hrd;
				ihq_pkg::S_DNR: begin
					if ($signed(left_q[PW-1:0]) > $signed(hrd[PW-1:0])) begin
						left_q <= hrd;
						cid_q  <= cid_q + 1'b1;
					end
				end
				ihq_pkg::S_DNC: begin
					if (!dn_stop) begin
						pos_q <= cid_q[SW-1:0];
						cid_q <= nc;
					end
				end
				default: ;
			endcase
		end
	end

	assign res_ext   = XW'(res_q);
	assign cnt_ext   = CXW'(cnt_q);
	assign busy      = (state_q != ihq_pkg::S_IDLE);
	assign done      = done_q;
	assign result_id = res_ext[7:0];
	assign error     = err_q;
	assign count     = cnt_ext[8:0];

endmodule
